@@ design/mpdu_payload_assembler_crc32_assert.svh @@
// assertion macros shared by the assembler modules
// expects clk_i and rst_ni in the scope of each use
`ifndef MPDU_PAYLOAD_ASSEMBLER_CRC32_ASSERT_SVH
`define MPDU_PAYLOAD_ASSEMBLER_CRC32_ASSERT_SVH
`ifndef SYNTHESIS
// checked only while out of reset
`define MPA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define MPA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MPA_ASSERT(name, prop, msg)
`define MPA_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

@@ design/mpa_pkg.sv @@
// types, constants and the crc byte update for the pdu payload assembler
// no dependencies
package mpa_pkg;

  localparam logic [6:0]  MAX_DATA_BLOCKS = 7'd127;
  localparam logic [31:0] CRC_POLY        = 32'h04C11DB7;
  localparam logic [31:0] CRC_XOR_OUT     = 32'hFFFFFFFF;
  localparam logic [4:0]  FMT_RATE34      = 5'h16;
  localparam logic [4:0]  FMT_TRUNK_A     = 5'h15;
  localparam logic [4:0]  FMT_TRUNK_B     = 5'h17;
  localparam logic [5:0]  SAP_TRUNK       = 6'h3D;
  localparam logic [5:0]  SAP_LONG_A      = 6'd61;
  localparam logic [5:0]  SAP_LONG_B      = 6'd63;
  localparam logic [6:0]  LONG_LIMIT      = 7'd10;
  localparam logic [6:0]  LONG_KEEP       = 7'd3;

  // byte positions
  localparam logic [4:0] HDR_POS_FMT   = 5'd0;
  localparam logic [4:0] HDR_POS_SAP   = 5'd1;
  localparam logic [4:0] HDR_POS_COUNT = 5'd6;
  localparam logic [4:0] HDR_POS_LAST  = 5'd11;
  localparam logic [4:0] R12_POS_LAST  = 5'd11;
  localparam logic [4:0] R34_POS_LAST  = 5'd17;
  localparam logic [4:0] R34_POS_SEQ   = 5'd0;
  localparam logic [4:0] R34_POS_SKIP  = 5'd1;
  localparam logic [2:0] TAIL_FULL     = 3'd4;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       in_header;
    logic [6:0] block_number;
    logic [6:0] block_seq;
    logic       last;
    logic       crc_ok;
    logic       trunking;
    logic       rate34;
  } out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       in_header;
    logic [6:0] block_number;
    logic [6:0] block_seq;
    logic       last;
    logic       trunking;
    logic       rate34;
    logic       truncated;
  } rec_t;

  // msb-first crc-32 over one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[31] ^ b[i];
      r  = {r[30:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

endpackage

@@ design/mpa_front.sv @@
// front end: tracks header and block framing, classifies each byte
// depends on mpa_pkg
module mpa_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  mpa_pkg::in_t     in_i,
  input  logic             q_full_i,
  output logic             in_stall_o,
  output logic             push_o,
  output mpa_pkg::rec_t    rec_o
);

  logic [4:0] bib_q, bib_d;
  logic [6:0] blk_q, blk_d;
  logic [6:0] total_q, total_d;
  logic [4:0] fmt_q, fmt_d;
  logic [5:0] sap_q, sap_d;
  logic       r34_q, r34_d;
  logic       trunc_q, trunc_d;
  logic [6:0] seq_q, seq_d;
  logic       busy_q, busy_d;

  logic       acc, start;
  logic [7:0] b;
  logic [4:0] bib_e;
  logic [6:0] blk_e, total_e, collect;
  logic [4:0] fmt_e;
  logic [5:0] sap_e;
  logic       r34_e, trunc_e, busy_e, emit, hdr, last;
  logic [6:0] seq_e, seq_out, raw;
  logic [4:0] last_pos;

  assign in_stall_o = q_full_i;
  assign acc   = in_valid_i & ~q_full_i;
  assign start = in_i.start_req;
  assign b     = in_i.data_byte;

  always_comb begin
    // a start byte sees cleared state
    bib_e   = start ? '0 : bib_q;
    blk_e   = start ? '0 : blk_q;
    total_e = start ? '0 : total_q;
    fmt_e   = start ? '0 : fmt_q;
    sap_e   = start ? '0 : sap_q;
    r34_e   = start ? 1'b0 : r34_q;
    trunc_e = start ? 1'b0 : trunc_q;
    seq_e   = start ? '0 : seq_q;
    busy_e  = start | busy_q;

    bib_d   = bib_e;
    blk_d   = blk_e;
    total_d = total_e;
    fmt_d   = fmt_e;
    sap_d   = sap_e;
    r34_d   = r34_e;
    trunc_d = trunc_e;
    seq_d   = seq_e;
    busy_d  = busy_e;

    emit     = 1'b1;
    hdr      = 1'b0;
    last     = 1'b0;
    raw      = b[6:0];
    last_pos = r34_e ? mpa_pkg::R34_POS_LAST : mpa_pkg::R12_POS_LAST;
    collect  = (trunc_e && (total_e > mpa_pkg::LONG_KEEP)) ? mpa_pkg::LONG_KEEP : total_e;

    if (blk_e == '0) begin
      hdr = 1'b1;
      if (bib_e == mpa_pkg::HDR_POS_FMT) begin
        fmt_d = b[4:0];
        r34_d = b[6] && (b[4:0] == mpa_pkg::FMT_RATE34);
      end else if (bib_e == mpa_pkg::HDR_POS_SAP) begin
        sap_d = b[5:0];
      end else if (bib_e == mpa_pkg::HDR_POS_COUNT) begin
        total_d = (raw > mpa_pkg::MAX_DATA_BLOCKS) ? mpa_pkg::MAX_DATA_BLOCKS : raw;
        trunc_d = ((sap_e == mpa_pkg::SAP_LONG_A) || (sap_e == mpa_pkg::SAP_LONG_B))
                  && (raw > mpa_pkg::LONG_LIMIT);
      end
      if (bib_e == mpa_pkg::HDR_POS_LAST) begin
        bib_d = '0;
        if (total_d == '0) begin
          last   = 1'b1;
          busy_d = 1'b0;
        end else begin
          blk_d = 7'd1;
        end
      end else begin
        bib_d = bib_e + 5'd1;
      end
    end else begin
      if (r34_e && (bib_e == mpa_pkg::R34_POS_SEQ)) begin
        seq_d = b[7:1];
        emit  = 1'b0;
      end else if (r34_e && (bib_e == mpa_pkg::R34_POS_SKIP)) begin
        emit = 1'b0;
      end
      if (bib_e == last_pos) begin
        bib_d = '0;
        if (blk_e >= collect) begin
          last   = 1'b1;
          busy_d = 1'b0;
        end else begin
          blk_d = blk_e + 7'd1;
        end
      end else begin
        bib_d = bib_e + 5'd1;
      end
    end

    seq_out = r34_d ? seq_d : '0;
    if (hdr) begin
      seq_out = '0;
    end
  end

  assign push_o = acc & busy_e & emit;

  always_comb begin
    rec_o.data_byte    = b;
    rec_o.in_header    = hdr;
    rec_o.block_number = blk_e;
    rec_o.block_seq    = seq_out;
    rec_o.last         = last;
    rec_o.trunking     = (sap_d == mpa_pkg::SAP_TRUNK) &&
                         ((fmt_d == mpa_pkg::FMT_TRUNK_A) || (fmt_d == mpa_pkg::FMT_TRUNK_B));
    rec_o.rate34       = r34_d;
    rec_o.truncated    = trunc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bib_q   <= '0;
      blk_q   <= '0;
      total_q <= '0;
      fmt_q   <= '0;
      sap_q   <= '0;
      r34_q   <= 1'b0;
      trunc_q <= 1'b0;
      seq_q   <= '0;
      busy_q  <= 1'b0;
    end else if (acc && busy_e) begin
      bib_q   <= bib_d;
      blk_q   <= blk_d;
      total_q <= total_d;
      fmt_q   <= fmt_d;
      sap_q   <= sap_d;
      r34_q   <= r34_d;
      trunc_q <= trunc_d;
      seq_q   <= seq_d;
      busy_q  <= busy_d;
    end
  end

endmodule

@@ design/mpa_queue.sv @@
// short queue of classified items between front and back
// depends on mpa_pkg and the assertion header
`include "mpdu_payload_assembler_crc32_assert.svh"
module mpa_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mpa_pkg::rec_t    rec_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output mpa_pkg::rec_t    rec_o
);

  mpa_pkg::rec_t                 mem_q [mpa_pkg::QDEPTH];
  logic [mpa_pkg::QPW-1:0]       wp_q, rp_q;
  logic [mpa_pkg::QCW-1:0]       count_q;

  assign full_o  = (count_q == mpa_pkg::QCW'(mpa_pkg::QDEPTH));
  assign empty_o = (count_q == '0);
  assign rec_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == mpa_pkg::QPW'(mpa_pkg::QDEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == mpa_pkg::QPW'(mpa_pkg::QDEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + mpa_pkg::QCW'(1);
        2'b01:   count_q <= count_q - mpa_pkg::QCW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `MPA_ASSERT(a_no_pop_empty, pop_i |-> !empty_o, "queue popped while empty")
  `MPA_ASSERT(a_no_push_full, push_i |-> !full_o, "queue pushed while full")
  `MPA_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (count_q == '0), "queue not empty in reset")

endmodule

@@ design/mpa_back.sv @@
// back end: crc-32 over the payload, tail compare and the output register
// depends on mpa_pkg and the assertion header
`include "mpdu_payload_assembler_crc32_assert.svh"
module mpa_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  mpa_pkg::rec_t    rec_i,
  output logic             pop_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output mpa_pkg::out_t    out_o
);

  logic [31:0]   crc_q, crc_d;
  logic [31:0]   tail_q, tail_d;
  logic [2:0]    cnt_q, cnt_d;
  logic          valid_q;
  mpa_pkg::out_t out_q, out_d;
  logic          ok;

  assign pop_o = ~q_empty_i & (~valid_q | ~out_stall_i);

  always_comb begin
    crc_d  = crc_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (rec_i.in_header) begin
      crc_d  = '0;
      tail_d = '0;
      cnt_d  = '0;
    end else begin
      // the four newest bytes wait in the tail until a later byte pushes them out
      if (cnt_q >= mpa_pkg::TAIL_FULL) begin
        crc_d = mpa_pkg::crc32_byte(crc_q, tail_q[31:24]);
      end else begin
        cnt_d = cnt_q + 3'd1;
      end
      tail_d = {tail_q[23:0], rec_i.data_byte};
    end
    ok = rec_i.in_header ? 1'b1 :
         (!rec_i.truncated && (cnt_d >= mpa_pkg::TAIL_FULL) &&
          (tail_d == (crc_d ^ mpa_pkg::CRC_XOR_OUT)));

    out_d.payload_byte = rec_i.data_byte;
    out_d.in_header    = rec_i.in_header;
    out_d.block_number = rec_i.block_number;
    out_d.block_seq    = rec_i.block_seq;
    out_d.last         = rec_i.last;
    out_d.crc_ok       = rec_i.last & ok;
    out_d.trunking     = rec_i.trunking;
    out_d.rate34       = rec_i.rate34;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        crc_q   <= crc_d;
        tail_q  <= tail_d;
        cnt_q   <= cnt_d;
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = out_q;

  `MPA_ASSERT(a_ok_only_last, valid_q |-> (!out_q.crc_ok || out_q.last),
              "crc_ok set on a byte that is not last")
  `MPA_ASSERT(a_tail_bound, cnt_q <= mpa_pkg::TAIL_FULL, "tail count beyond four")
  `MPA_ASSERT(a_hdr_clears, (pop_o && rec_i.in_header) |=> (crc_q == '0 && cnt_q == '0),
              "crc state not cleared by header item")

endmodule

@@ design/mpdu_payload_assembler_crc32.sv @@
// top level of the multi-block pdu payload assembler with crc-32 check
// depends on mpa_pkg, mpa_front, mpa_queue and mpa_back
//
// usage:
//   input channel (in_valid_i, in_stall_o, in_i) carries one decoded pdu byte per
//   item, header first; start_req marks header byte 0 and restarts assembly.
//   output channel (out_valid_o, out_stall_i, out_o) carries one forwarded byte per
//   item with header flag, block number, rate 3/4 sequence, last and crc_ok.
//   bytes outside a pdu and the two rate 3/4 block-header bytes give no item.
// path: an accepted byte is written into the queue, then into the output register.
// throughput: one byte per cycle while in_stall_o is low; the byte-wide crc update in
//   the back end and the framing counters in the front end each update once per byte.
// the front end and the back end are parted by a two-entry queue; in_stall_o rises
//   only when that queue is full, so the front keeps taking bytes while a result
//   waits in the output register under out_stall_i.
// a stalled result holds its value until taken.
// reset clears framing state, the queue and the output valid; no pdu is in progress
//   afterwards, so bytes are ignored until one with start_req arrives.
module mpdu_payload_assembler_crc32 (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mpa_pkg::in_t     in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mpa_pkg::out_t    out_o
);

  logic          push, pop, q_full, q_empty;
  mpa_pkg::rec_t rec_in, rec_out;

  mpa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .rec_o      (rec_in)
  );

  mpa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .rec_o   (rec_out)
  );

  mpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .rec_i       (rec_out),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule
